FILE: rtl/core/dma_channel_allocator_assert.svh
// Assertion macros for the DMA channel allocator.
`ifndef DMA_CHANNEL_ALLOCATOR_ASSERT_SVH
`define DMA_CHANNEL_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define DMACA_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dma_channel_allocator: assertion failed");

// Next-cycle implication, checked outside reset.
`define DMACA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dma_channel_allocator: assertion failed");

`endif

FILE: rtl/core/dmaca_pkg.sv
// Package: pool sizes, field widths and codes of the DMA channel allocator.
`timescale 1ns / 1ps

package dmaca_pkg;

    localparam int FULL_CHANNELS = 8;
    localparam int HALF_CHANNELS = 6;
    localparam int FIFO_CHANNELS = 6;

    localparam int HALF_BASE    = FULL_CHANNELS;
    localparam int FIFO_BASE    = FULL_CHANNELS + HALF_CHANNELS;
    localparam int ALL_CHANNELS = FULL_CHANNELS + HALF_CHANNELS + FIFO_CHANNELS;

    // payload field widths
    localparam int OP_W     = 1;
    localparam int KIND_W   = 4;
    localparam int CHAN_W   = 5;
    localparam int STATUS_W = 2;

    // list heads hold the pool size as the end mark
    localparam int FULL_HEAD_W = $clog2(FULL_CHANNELS + 1);
    localparam int HALF_HEAD_W = $clog2(HALF_CHANNELS + 1);
    localparam int FULL_IDX_W  = (FULL_CHANNELS > 1) ? $clog2(FULL_CHANNELS) : 1;
    localparam int HALF_IDX_W  = (HALF_CHANNELS > 1) ? $clog2(HALF_CHANNELS) : 1;
    localparam int HELD_IDX_W  = $clog2(ALL_CHANNELS);

    localparam logic [OP_W-1:0] OP_REQ  = 1'b0;
    localparam logic [OP_W-1:0] OP_FREE = 1'b1;

    localparam logic [KIND_W-1:0] KIND_FULL       = 4'd0;
    localparam logic [KIND_W-1:0] KIND_HALF       = 4'd1;
    localparam logic [KIND_W-1:0] KIND_VFIFO      = 4'd2;
    localparam logic [KIND_W-1:0] KIND_UART_FIRST = 4'd3;
    localparam logic [KIND_W-1:0] KIND_UART_END   = KIND_W'(3 + FIFO_CHANNELS);

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NONE    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_UNKNOWN = 2'd2;

endpackage

FILE: rtl/core/dmaca_if.sv
// Request and response channel interfaces of the DMA channel allocator.
`timescale 1ns / 1ps

interface dmaca_req_if import dmaca_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [KIND_W-1:0] req_kind;
    logic [CHAN_W-1:0] chan_id;

    modport source (output valid, output op, output req_kind, output chan_id, input ready);
    modport sink   (input valid, input op, input req_kind, input chan_id, output ready);
endinterface

interface dmaca_rsp_if import dmaca_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [CHAN_W-1:0]   granted_chan;

    modport source (output valid, output status, output granted_chan, input ready);
    modport sink   (input valid, input status, input granted_chan, output ready);
endinterface

FILE: rtl/core/dma_channel_allocator.sv
// DMA channel allocator: free-list pools for full and half channels, flags for vfifo channels.
//
// Usage
//   req : one request per handshake, op = request or free, req_kind picks the pool
//         (full, half, or the vfifo of one UART), chan_id names the channel to free.
//   rsp : one response per request: status (ok, none available, unknown type) and
//         the granted channel number, 0 when nothing was granted.
// Timing
//   A request is captured in an input register, decoded against the pool state
//   and written to the response register once the response slot is free or being
//   drained. The pool update happens on that same edge, so a following request
//   sees it; one request per cycle is sustained while rsp is not held off.
//   The rate is set by the single pass through the head/link lookup of each list.
// Stalls
//   While rsp is held off, the finished response waits in its register and one
//   more request waits in the input register; req.ready drops only when both are full.
// Reset
//   Both free lists are rebuilt in ascending order (channel 0 at the head) and all
//   held flags are cleared at once; the block takes requests straight after reset.
`timescale 1ns / 1ps

module dma_channel_allocator import dmaca_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    dmaca_req_if.sink        req,
    dmaca_rsp_if.source      rsp
);

    // input register
    logic              in_vld_reg;
    logic [OP_W-1:0]   in_op_reg;
    logic [KIND_W-1:0] in_kind_reg;
    logic [CHAN_W-1:0] in_chan_reg;

    // response register
    logic                rsp_vld_reg;
    logic [STATUS_W-1:0] rsp_status_reg;
    logic [CHAN_W-1:0]   rsp_chan_reg;

    // pool state
    logic [FULL_HEAD_W-1:0] full_head_reg, full_head_next;
    logic [FULL_HEAD_W-1:0] full_next_reg [FULL_CHANNELS];
    logic [FULL_HEAD_W-1:0] full_next_next [FULL_CHANNELS];
    logic [HALF_HEAD_W-1:0] half_head_reg, half_head_next;
    logic [HALF_HEAD_W-1:0] half_next_reg [HALF_CHANNELS];
    logic [HALF_HEAD_W-1:0] half_next_next [HALF_CHANNELS];
    logic [ALL_CHANNELS-1:0] held_reg, held_next;

    logic                grant_ok;
    logic [STATUS_W-1:0] status_val;
    logic [CHAN_W-1:0]   chan_val;
    logic [CHAN_W-1:0]   half_off;
    logic                advance;
    logic                full_empty;
    logic                half_empty;
    logic                uart_kind;
    logic [CHAN_W-1:0]   uart_chan;
    logic                free_full;

    // the input register moves on when the response slot is free or being drained
    assign advance   = in_vld_reg && (!rsp_vld_reg || rsp.ready);
    assign req.ready = !in_vld_reg || advance;

    assign rsp.valid        = rsp_vld_reg;
    assign rsp.status       = rsp_status_reg;
    assign rsp.granted_chan = rsp_chan_reg;

    assign full_empty = (full_head_reg >= FULL_HEAD_W'(FULL_CHANNELS));
    assign half_empty = (half_head_reg >= HALF_HEAD_W'(HALF_CHANNELS));
    assign uart_kind  = (in_kind_reg >= KIND_UART_FIRST) && (in_kind_reg < KIND_UART_END);
    assign uart_chan  = CHAN_W'(FIFO_BASE) + CHAN_W'(in_kind_reg - KIND_UART_FIRST);
    assign half_off   = in_chan_reg - CHAN_W'(HALF_BASE);
    assign free_full  = (in_op_reg == OP_FREE) && (in_chan_reg < CHAN_W'(FULL_CHANNELS));
    // grant_ok only marks a successful grant, for the checks below
    assign grant_ok   = (status_val == ST_OK) && (in_op_reg == OP_REQ);

    always_comb
    begin
        full_head_next = full_head_reg;
        full_next_next = full_next_reg;
        half_head_next = half_head_reg;
        half_next_next = half_next_reg;
        held_next      = held_reg;
        status_val     = ST_OK;
        chan_val       = '0;

        if (in_op_reg == OP_REQ)
        begin
            priority if (in_kind_reg == KIND_FULL)
            begin
                if (full_empty)
                begin
                    status_val = ST_NONE;
                end
                else
                begin
                    held_next[HELD_IDX_W'(full_head_reg)] = 1'b1;
                    full_head_next = full_next_reg[full_head_reg[FULL_IDX_W-1:0]];
                    chan_val       = CHAN_W'(full_head_reg);
                end
            end
            else if (in_kind_reg == KIND_HALF)
            begin
                if (half_empty)
                begin
                    status_val = ST_NONE;
                end
                else
                begin
                    chan_val = CHAN_W'(HALF_BASE) + CHAN_W'(half_head_reg);
                    held_next[HELD_IDX_W'(chan_val)] = 1'b1;
                    half_head_next = half_next_reg[half_head_reg[HALF_IDX_W-1:0]];
                end
            end
            else if (uart_kind)
            begin
                if (held_reg[HELD_IDX_W'(uart_chan)])
                begin
                    status_val = ST_NONE;
                end
                else
                begin
                    held_next[HELD_IDX_W'(uart_chan)] = 1'b1;
                    chan_val = uart_chan;
                end
            end
            else
            begin
                // generic vfifo and codes past the last UART
                status_val = ST_UNKNOWN;
            end
        end
        else
        begin
            priority if (free_full)
            begin
                full_next_next[in_chan_reg[FULL_IDX_W-1:0]] = full_head_reg;
                full_head_next = FULL_HEAD_W'(in_chan_reg);
                held_next[HELD_IDX_W'(in_chan_reg)] = 1'b0;
            end
            else if (in_chan_reg < CHAN_W'(FIFO_BASE))
            begin
                half_next_next[half_off[HALF_IDX_W-1:0]] = half_head_reg;
                half_head_next = HALF_HEAD_W'(half_off);
                held_next[HELD_IDX_W'(in_chan_reg)] = 1'b0;
            end
            else if (in_chan_reg < CHAN_W'(ALL_CHANNELS))
            begin
                held_next[HELD_IDX_W'(in_chan_reg)] = 1'b0;
            end
            else
            begin
                status_val = ST_UNKNOWN;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg    <= 1'b0;
            rsp_vld_reg   <= 1'b0;
            full_head_reg <= '0;
            half_head_reg <= '0;
            held_reg      <= '0;
            for (int i = 0; i < FULL_CHANNELS; i++)
            begin
                full_next_reg[i] <= FULL_HEAD_W'(i + 1);
            end
            for (int i = 0; i < HALF_CHANNELS; i++)
            begin
                half_next_reg[i] <= HALF_HEAD_W'(i + 1);
            end
        end
        else
        begin
            if (req.ready)
            begin
                in_vld_reg <= req.valid;
            end
            if (advance)
            begin
                rsp_vld_reg   <= 1'b1;
                full_head_reg <= full_head_next;
                full_next_reg <= full_next_next;
                half_head_reg <= half_head_next;
                half_next_reg <= half_next_next;
                held_reg      <= held_next;
            end
            else if (rsp.ready)
            begin
                rsp_vld_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            in_op_reg   <= req.op;
            in_kind_reg <= req.req_kind;
            in_chan_reg <= req.chan_id;
        end
        if (advance)
        begin
            rsp_status_reg <= status_val;
            rsp_chan_reg   <= chan_val;
        end
    end

`include "dma_channel_allocator_assert.svh"

    // heads never point past the end mark
    `DMACA_ASSERT_NOW(a_full_head_range, 1'b1, full_head_reg <= FULL_HEAD_W'(FULL_CHANNELS))
    `DMACA_ASSERT_NOW(a_half_head_range, 1'b1, half_head_reg <= HALF_HEAD_W'(HALF_CHANNELS))
    // a freed full channel becomes the head of its list
    `DMACA_ASSERT_NEXT(a_full_push, advance && free_full,
        full_head_reg == $past(FULL_HEAD_W'(in_chan_reg)))
    // every granted channel is marked held
    `DMACA_ASSERT_NEXT(a_grant_held, advance && grant_ok,
        held_reg[HELD_IDX_W'(rsp_chan_reg)])
    // each processed request leaves a response behind
    `DMACA_ASSERT_NEXT(a_rsp_follows, advance, rsp_vld_reg)

endmodule

FILE: tb/tb_dma_channel_allocator.sv
// Self-checking testbench for the DMA channel allocator.
`timescale 1ns / 1ps

module tb_dma_channel_allocator;
    import dmaca_pkg::*;

    localparam int RANDOM_REQUESTS = 650;
    // the last stretch of random requests is unconstrained and may corrupt the lists
    localparam int NOISE_REQUESTS  = 110;
    localparam int PHASE_LEN       = 40;
    localparam int CALM_FIRST      = 200;
    localparam int CALM_LAST       = 330;
    localparam int IDLE_PCT        = 13;
    localparam int DRAIN_CYCLES    = 10;
    localparam int CYCLE_LIMIT     = 200000;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [CHAN_W-1:0]   chan;
    } grant_t;

    typedef struct {
        logic [OP_W-1:0]   op;
        logic [KIND_W-1:0] kind;
        logic [CHAN_W-1:0] id;
        bit                known;
        grant_t            typed;
    } stim_row_t;

    logic clk;
    logic rst_n;
    bit   calm;
    int   errors;
    int   cycles;

    dmaca_req_if req_ch ();
    dmaca_rsp_if rsp_ch ();

    dma_channel_allocator dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source)
    );

    // Shadow of the pool state: two LIFO free lists and the held flags
    logic [FULL_HEAD_W-1:0] full_head;
    logic [FULL_HEAD_W-1:0] full_link [FULL_CHANNELS];
    logic [HALF_HEAD_W-1:0] half_head;
    logic [HALF_HEAD_W-1:0] half_link [HALF_CHANNELS];
    logic                   chan_held [ALL_CHANNELS];

    grant_t    grant_q [$];
    stim_row_t directed_rows [$];

    // Works out the response to one request and updates the shadow state
    function automatic grant_t predict_grant(input logic [OP_W-1:0] op,
                                             input logic [KIND_W-1:0] kind,
                                             input logic [CHAN_W-1:0] id);
        grant_t g;
        int     c;
        g.status = ST_OK;
        g.chan   = '0;
        if (op == OP_REQ)
        begin
            if (kind == KIND_FULL)
            begin
                if (full_head >= FULL_CHANNELS)
                    g.status = ST_NONE;
                else
                begin
                    c = int'(full_head);
                    chan_held[c] = 1'b1;
                    full_head    = full_link[c];
                    g.chan       = CHAN_W'(c);
                end
            end
            else if (kind == KIND_HALF)
            begin
                if (half_head >= HALF_CHANNELS)
                    g.status = ST_NONE;
                else
                begin
                    c = int'(half_head);
                    chan_held[HALF_BASE + c] = 1'b1;
                    half_head = half_link[c];
                    g.chan    = CHAN_W'(HALF_BASE + c);
                end
            end
            else if (kind >= KIND_UART_FIRST && kind < KIND_UART_END)
            begin
                c = FIFO_BASE + int'(kind - KIND_UART_FIRST);
                if (chan_held[c])
                    g.status = ST_NONE;
                else
                begin
                    chan_held[c] = 1'b1;
                    g.chan       = CHAN_W'(c);
                end
            end
            else
                g.status = ST_UNKNOWN;
        end
        else
        begin
            // frees are taken on trust: no check that the channel was held
            if (id < FULL_CHANNELS)
            begin
                full_link[id[FULL_IDX_W-1:0]] = full_head;
                full_head     = FULL_HEAD_W'(id);
                chan_held[id] = 1'b0;
            end
            else if (id < FIFO_BASE)
            begin
                c = int'(id) - HALF_BASE;
                half_link[c]  = half_head;
                half_head     = HALF_HEAD_W'(c);
                chan_held[id] = 1'b0;
            end
            else if (id < ALL_CHANNELS)
                chan_held[id] = 1'b0;
            else
                g.status = ST_UNKNOWN;
        end
        return g;
    endfunction

    task automatic add_row(input logic [OP_W-1:0] op, input logic [KIND_W-1:0] kind,
                           input logic [CHAN_W-1:0] id, input bit known,
                           input logic [STATUS_W-1:0] status, input int chan);
        stim_row_t r;
        r.op           = op;
        r.kind         = kind;
        r.id           = id;
        r.known        = known;
        r.typed.status = status;
        r.typed.chan   = CHAN_W'(chan);
        directed_rows.push_back(r);
    endtask

    // Predicts, queues the expected response, then drives one request until accepted
    task automatic issue_request(input logic [OP_W-1:0] op, input logic [KIND_W-1:0] kind,
                                 input logic [CHAN_W-1:0] id, input bit known,
                                 input grant_t typed);
        grant_t g;
        g = predict_grant(op, kind, id);
        grant_q.push_back(known ? typed : g);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.op       <= op;
        req_ch.req_kind <= kind;
        req_ch.chan_id  <= id;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Response side stalls at random, except in the calm stretch
    initial
    begin
        rsp_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            rsp_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Response checker: each accepted response against the oldest expectation
    always @(posedge clk)
    begin : rsp_check
        grant_t e;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (grant_q.size() == 0)
            begin
                $display("%0t: unexpected response, expected none, actual status %0d chan %0d",
                         $time, rsp_ch.status, rsp_ch.granted_chan);
                errors = errors + 1;
            end
            else
            begin
                e = grant_q.pop_front();
                if (rsp_ch.status !== e.status)
                begin
                    $display("%0t: status mismatch, expected %0d, actual %0d",
                             $time, e.status, rsp_ch.status);
                    errors = errors + 1;
                end
                if (rsp_ch.granted_chan !== e.chan)
                begin
                    $display("%0t: granted_chan mismatch, expected %0d, actual %0d",
                             $time, e.chan, rsp_ch.granted_chan);
                    errors = errors + 1;
                end
            end
        end
    end

    initial
    begin : stimulus
        int                i;
        int                roll;
        int                start;
        int                held_cnt;
        int                c;
        bit                fill;
        logic [OP_W-1:0]   op;
        logic [KIND_W-1:0] kind;
        logic [CHAN_W-1:0] id;
        grant_t            none_typed;

        errors          = 0;
        cycles          = 0;
        calm            = 1'b0;
        none_typed      = '0;
        rst_n           = 1'b0;
        req_ch.valid    <= 1'b0;
        req_ch.op       <= OP_REQ;
        req_ch.req_kind <= KIND_FULL;
        req_ch.chan_id  <= '0;

        // shadow state after reset
        full_head = '0;
        for (i = 0; i < FULL_CHANNELS; i++)
            full_link[i] = FULL_HEAD_W'(i + 1);
        half_head = '0;
        for (i = 0; i < HALF_CHANNELS; i++)
            half_link[i] = HALF_HEAD_W'(i + 1);
        for (i = 0; i < ALL_CHANNELS; i++)
            chan_held[i] = 1'b0;

        // Directed table: fixed results where they follow straight from reset
        add_row(OP_REQ, KIND_FULL, '0, 1'b1, ST_OK, 0);
        for (i = 0; i < HALF_CHANNELS; i++)
            add_row(OP_REQ, KIND_HALF, '1, 1'b1, ST_OK, HALF_BASE + i);
        add_row(OP_REQ, KIND_HALF, '0, 1'b1, ST_NONE, 0);              // half list empty
        add_row(OP_REQ, KIND_UART_FIRST, '0, 1'b1, ST_OK, FIFO_BASE);
        add_row(OP_REQ, KIND_UART_FIRST, '0, 1'b1, ST_NONE, 0);        // vfifo already held
        add_row(OP_REQ, KIND_UART_END - 1'b1, '0, 1'b1, ST_OK, ALL_CHANNELS - 1);
        add_row(OP_REQ, KIND_VFIFO, '0, 1'b1, ST_UNKNOWN, 0);          // generic vfifo
        add_row(OP_REQ, KIND_UART_END, '0, 1'b1, ST_UNKNOWN, 0);
        add_row(OP_REQ, '1, '1, 1'b1, ST_UNKNOWN, 0);
        add_row(OP_FREE, '1, '1, 1'b1, ST_UNKNOWN, 0);                  // past last vfifo
        add_row(OP_FREE, KIND_FULL, CHAN_W'(ALL_CHANNELS), 1'b1, ST_UNKNOWN, 0);
        add_row(OP_FREE, KIND_FULL, CHAN_W'(ALL_CHANNELS - 1), 1'b1, ST_OK, 0);
        add_row(OP_FREE, KIND_HALF, CHAN_W'(ALL_CHANNELS - 1), 1'b1, ST_OK, 0); // unheld
        add_row(OP_REQ, KIND_UART_END - 1'b1, '0, 1'b1, ST_OK, ALL_CHANNELS - 1);
        add_row(OP_FREE, '1, CHAN_W'(FIFO_BASE - 1), 1'b1, ST_OK, 0);   // half flag cleared
        add_row(OP_REQ, KIND_HALF, '0, 1'b0, ST_OK, 0);
        add_row(OP_FREE, KIND_UART_FIRST, '0, 1'b1, ST_OK, 0);
        add_row(OP_REQ, KIND_FULL, '0, 1'b0, ST_OK, 0);
        add_row(OP_FREE, KIND_HALF, CHAN_W'(HALF_BASE), 1'b1, ST_OK, 0);
        add_row(OP_REQ, KIND_HALF, '0, 1'b0, ST_OK, 0);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[k])
            issue_request(directed_rows[k].op, directed_rows[k].kind, directed_rows[k].id,
                          directed_rows[k].known, directed_rows[k].typed);

        // Random part: alternating fill and drain phases keep the lists consistent
        // and push them to empty and full; the tail is raw noise.
        for (i = 0; i < RANDOM_REQUESTS; i++)
        begin
            calm = (i >= CALM_FIRST && i <= CALM_LAST);
            fill = ((i / PHASE_LEN) % 2) == 0;
            roll = $urandom_range(0, 99);
            held_cnt = 0;
            for (c = 0; c < ALL_CHANNELS; c++)
                held_cnt += chan_held[c];
            kind = KIND_W'($urandom_range(0, 15));
            id   = CHAN_W'($urandom_range(0, 31));
            if (i >= RANDOM_REQUESTS - NOISE_REQUESTS)
                op = OP_W'($urandom_range(0, 1));
            else if (roll < 5)
            begin
                // harmless oddities: rejected kinds, out-of-range or vfifo frees
                op = OP_W'($urandom_range(0, 1));
                if (op == OP_REQ)
                    kind = ($urandom_range(0, 1) == 0) ? KIND_VFIFO
                                                       : KIND_W'($urandom_range(9, 15));
                else
                    id = CHAN_W'($urandom_range(FIFO_BASE, 31));
            end
            else if (held_cnt == 0 || (fill ? roll < 78 : roll < 25))
            begin
                op   = OP_REQ;
                roll = $urandom_range(0, 9);
                if (roll < 4)
                    kind = KIND_FULL;
                else if (roll < 7)
                    kind = KIND_HALF;
                else
                    kind = KIND_UART_FIRST + KIND_W'($urandom_range(0, FIFO_CHANNELS - 1));
            end
            else
            begin
                // free a channel that is really held
                op    = OP_FREE;
                start = $urandom_range(0, ALL_CHANNELS - 1);
                for (c = 0; c < ALL_CHANNELS; c++)
                begin
                    if (chan_held[(start + c) % ALL_CHANNELS])
                    begin
                        id = CHAN_W'((start + c) % ALL_CHANNELS);
                        break;
                    end
                end
            end
            issue_request(op, kind, id, 1'b0, none_typed);
        end
        req_ch.valid <= 1'b0;
        calm = 1'b0;

        while (grant_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
